>>> hdl/msgp_pkg.sv
// msgp_pkg: constants, payload structs and pipeline stage types for the
// multi-stop gradient pixel block. No dependencies.
package msgp_pkg;

   // Table depth and widest row; the derived widths below come from these.
   localparam int MAX_STOPS = 16;
   localparam int MAX_WIDTH = 4096;

   // Fixed field widths of the transaction and register payloads.
   localparam int COLOR_W     = 24;
   localparam int CH_W        = 8;
   localparam int NUM_CH      = 3;
   localparam int X_W         = 12;
   localparam int STOP_IDX_W  = 4;
   localparam int ROW_W_W     = 13;
   localparam int STOP_CNT_W  = 5;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_IDX_W   = 2;

   // Derived internal widths.
   localparam int IDX_W  = $clog2(MAX_STOPS);   // stop table address
   localparam int DEN_W  = $clog2(MAX_WIDTH);   // row width minus one
   localparam int POS_W  = DEN_W + IDX_W;       // x * (n - 1)
   localparam int PROD_W = CH_W + DEN_W;        // |diff| * rem

   // Edges from the accepting edge to the edge that takes the result.
   localparam int RSP_DELAY = IDX_W + CH_W + 4;

   typedef enum logic [0:0] {
      OP_WRITE_STOP = 1'b0,
      OP_PIXEL      = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH   = 2'd0,
      CSR_STOP_COUNT  = 2'd1,
      CSR_START_COLOR = 2'd2,
      CSR_END_COLOR   = 2'd3
   } csr_index_type;

   typedef struct packed {
      op_type                  operation;
      logic [STOP_IDX_W-1:0]   stop_index;
      logic [COLOR_W-1:0]      stop_color;
      logic [X_W-1:0]          pixel_x;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0]      pixel_color;
      logic [X_W-1:0]          pixel_column;
   } rsp_type;

   // Front pipe: stop-select division, also carries stop writes in order.
   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic [STOP_IDX_W-1:0]   widx;
      logic [COLOR_W-1:0]      wcolor;
      logic [DEN_W-1:0]        x;
      logic [POS_W-1:0]        rem;
      logic [IDX_W-1:0]        quo;
   } front_type;

   // Between the table read and the blend.
   typedef struct packed {
      logic                    valid;
      logic [DEN_W-1:0]        x;
      logic [DEN_W-1:0]        rem;
      logic                    hi;
   } meta_type;

   typedef struct packed {
      logic [CH_W-1:0]         base;
      logic                    neg;
      logic [PROD_W-1:0]       rem;
      logic [CH_W-1:0]         quo;
   } chan_type;

   // Back pipe: per-channel blend division.
   typedef struct packed {
      logic                    valid;
      logic [DEN_W-1:0]        x;
      chan_type [NUM_CH-1:0]   ch;
   } back_type;

endpackage

>>> hdl/multi_stop_gradient_pixel.sv
// multi_stop_gradient_pixel: top level, stop table memory and the full
// pixel pipeline. Depends on msgp_pkg.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high
//    and busy low. operation selects a stop write (stop_index, stop_color go
//    into the stop table, no result) or a pixel (pixel_x, one result).
//  - Result channel: rsp_valid is high for exactly one cycle per pixel, with
//    rsp_data holding the color and the clamped column. The receiver cannot
//    stall; results leave in command order.
//  - Register port: csr_we/csr_index/csr_wdata write row_width, stop_count,
//    start_color and end_color. Write only while the pipe is
//    empty; clamped forms (row width minus one, last stop index) are kept.
//  - Throughput: one transaction per cycle, sustained, of either kind.
//  - Pipeline: IDX_W + CH_W + 4 register stages, the first loaded by the
//    accepting edge: one input stage, IDX_W steps of the stop-select
//    divider, the table read, the color multiply, CH_W steps of the blend
//    divider, the output reg.
//  - Reset: synchronous; busy is high during reset and drops right after.
//    All pipe valids clear; the stop table is not cleared and holds
//    unknown colors until written.
module multi_stop_gradient_pixel (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  msgp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output msgp_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  msgp_pkg::csr_index_type          csr_index,
   input  logic [msgp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import msgp_pkg::*;

   // ---------------------------------------------------------------
   // Control / configuration
   // ---------------------------------------------------------------
   logic                  busy_ff;
   logic [DEN_W-1:0]      den_ff, den_in;     // row width - 1 (clamped)
   logic [DEN_W-1:0]      dvs_ff, dvs_in;     // divisor, never zero
   logic                  tbl_ff, tbl_in;     // two or more stops
   logic [IDX_W-1:0]      nm1_ff, nm1_in;     // last stop index in use
   logic [COLOR_W-1:0]    start_ff, end_ff;
   logic [ROW_W_W-1:0]    rw;
   logic [STOP_CNT_W-1:0] sc;

   always_comb begin
      rw = csr_wdata[ROW_W_W-1:0];
      // zero width acts as one, too wide saturates
      if (rw == '0) begin
         den_in = '0;
      end else if (32'(rw) > MAX_WIDTH) begin
         den_in = DEN_W'(MAX_WIDTH - 1);
      end else begin
         den_in = DEN_W'(rw - 1'b1);
      end
      // width of one: numerator is always zero, any nonzero divisor works
      dvs_in = (den_in == '0) ? DEN_W'(1) : den_in;

      sc     = csr_wdata[STOP_CNT_W-1:0];
      tbl_in = (32'(sc) >= 2);
      if (32'(sc) > MAX_STOPS) begin
         nm1_in = IDX_W'(MAX_STOPS - 1);
      end else if (tbl_in) begin
         nm1_in = IDX_W'(sc - 1'b1);
      end else begin
         // start/end blend runs as a two-stop gradient
         nm1_in = IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         den_ff   <= '0;
         dvs_ff   <= DEN_W'(1);
         tbl_ff   <= 1'b0;
         nm1_ff   <= IDX_W'(1);
         start_ff <= '0;
         end_ff   <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROW_WIDTH: begin
                  den_ff <= den_in;
                  dvs_ff <= dvs_in;
               end
               CSR_STOP_COUNT: begin
                  tbl_ff <= tbl_in;
                  nm1_ff <= nm1_in;
               end
               CSR_START_COLOR: begin
                  start_ff <= csr_wdata[COLOR_W-1:0];
               end
               CSR_END_COLOR: begin
                  end_ff <= csr_wdata[COLOR_W-1:0];
               end
            endcase
         end
      end
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------
   // Input stage: clamp column, form x * (n - 1)
   // ---------------------------------------------------------------
   logic              req_accept;
   logic [DEN_W-1:0]  x_clamp;
   front_type         div_ff [IDX_W+1];
   front_type         div_in [IDX_W+1];

   assign req_accept = start && !busy_ff;

   always_comb begin
      x_clamp = (32'(req_data.pixel_x) > 32'(den_ff)) ? den_ff
                                                       : DEN_W'(req_data.pixel_x);
      div_in[0].valid  = req_accept;
      div_in[0].op     = req_data.operation;
      div_in[0].widx   = req_data.stop_index;
      div_in[0].wcolor = req_data.stop_color;
      div_in[0].x      = x_clamp;
      div_in[0].rem    = POS_W'(x_clamp) * POS_W'(nm1_ff);
      div_in[0].quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].valid <= 1'b0;
      end else begin
         div_ff[0] <= div_in[0];
      end
   end

   // ---------------------------------------------------------------
   // Stop-select divider: one quotient bit per stage
   // ---------------------------------------------------------------
   for (genvar g = 0; g < IDX_W; g++) begin : g_div
      localparam int SH = IDX_W - 1 - g;
      logic [POS_W:0] trial;

      always_comb begin
         trial          = {1'b0, div_ff[g].rem} - ((POS_W+1)'(dvs_ff) << SH);
         div_in[g+1]     = div_ff[g];
         if (!trial[POS_W]) begin
            div_in[g+1].rem = trial[POS_W-1:0];
         end
         div_in[g+1].quo = IDX_W'({div_ff[g].quo, !trial[POS_W]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[g+1].valid <= 1'b0;
         end else begin
            div_ff[g+1] <= div_in[g+1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Stop table. Writes and reads happen at the same pipe stage, so
   // they stay in transaction order and never touch the same entry in
   // one cycle (one transaction per stage): no forwarding needed.
   // ---------------------------------------------------------------
   front_type          fin;
   logic [IDX_W-1:0]   rd_j;
   logic               wr_en;
   logic [COLOR_W-1:0] stop_table [MAX_STOPS];
   logic [COLOR_W-1:0] rda_ff, rdb_ff;
   meta_type           meta_ff, meta_in;

   always_comb begin
      fin   = div_ff[IDX_W];
      // next stop, held at the last one on the final column
      rd_j  = (fin.quo == nm1_ff) ? fin.quo : IDX_W'(fin.quo + 1'b1);
      wr_en = fin.valid && (fin.op == OP_WRITE_STOP)
              && (32'(fin.widx) < MAX_STOPS);

      meta_in.valid = fin.valid && (fin.op == OP_PIXEL);
      meta_in.x     = fin.x;
      meta_in.rem   = DEN_W'(fin.rem);    // below the divisor
      meta_in.hi    = (fin.quo != '0);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stop_table[IDX_W'(fin.widx)] <= fin.wcolor;
      end
      rda_ff <= stop_table[fin.quo];
      rdb_ff <= stop_table[rd_j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff <= meta_in;
      end
   end

   // ---------------------------------------------------------------
   // Color multiply: |c2 - c1| * rem per channel
   // ---------------------------------------------------------------
   back_type           blend_ff [CH_W+1];
   back_type           blend_in [CH_W+1];
   logic [COLOR_W-1:0] col_a, col_b;

   always_comb begin : p_mul
      logic [CH_W-1:0] a8, b8, mag;
      col_a = tbl_ff ? rda_ff : (meta_ff.hi ? end_ff : start_ff);
      col_b = tbl_ff ? rdb_ff : end_ff;
      blend_in[0].valid = meta_ff.valid;
      blend_in[0].x     = meta_ff.x;
      for (int c = 0; c < NUM_CH; c++) begin
         a8  = col_a[c*CH_W +: CH_W];
         b8  = col_b[c*CH_W +: CH_W];
         mag = (b8 < a8) ? (a8 - b8) : (b8 - a8);
         blend_in[0].ch[c].base = a8;
         blend_in[0].ch[c].neg  = (b8 < a8);
         blend_in[0].ch[c].rem  = PROD_W'(mag) * PROD_W'(meta_ff.rem);
         blend_in[0].ch[c].quo  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff[0].valid <= 1'b0;
      end else begin
         blend_ff[0] <= blend_in[0];
      end
   end

   // ---------------------------------------------------------------
   // Blend divider: one quotient bit per stage, three channels abreast
   // ---------------------------------------------------------------
   for (genvar g = 0; g < CH_W; g++) begin : g_blend
      localparam int SH = CH_W - 1 - g;
      logic [PROD_W:0] trial [NUM_CH];

      always_comb begin
         blend_in[g+1] = blend_ff[g];
         for (int c = 0; c < NUM_CH; c++) begin
            trial[c] = {1'b0, blend_ff[g].ch[c].rem}
                       - ((PROD_W+1)'(dvs_ff) << SH);
            if (!trial[c][PROD_W]) begin
               blend_in[g+1].ch[c].rem = trial[c][PROD_W-1:0];
            end
            blend_in[g+1].ch[c].quo =
               CH_W'({blend_ff[g].ch[c].quo, !trial[c][PROD_W]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            blend_ff[g+1].valid <= 1'b0;
         end else begin
            blend_ff[g+1] <= blend_in[g+1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Floor correction and output register
   // ---------------------------------------------------------------
   back_type  last;
   rsp_type   rsp_in, rsp_data_ff;
   logic      rsp_valid_ff;

   always_comb begin : p_out
      logic [CH_W-1:0] qfix;
      last = blend_ff[CH_W];
      rsp_in.pixel_color = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         // negative slope rounds the magnitude up
         qfix = last.ch[c].quo
                + CH_W'(last.ch[c].neg && (last.ch[c].rem != '0));
         rsp_in.pixel_color[c*CH_W +: CH_W] =
            last.ch[c].neg ? (last.ch[c].base - qfix)
                           : (last.ch[c].base + qfix);
      end
      rsp_in.pixel_column = X_W'(last.x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_has_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(start && !busy_ff
                             && req_data.operation == OP_PIXEL, RSP_DELAY))
      else $error("result strobe without a pixel transaction");

   a_pixel_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff && req_data.operation == OP_PIXEL)
      |-> ##RSP_DELAY rsp_valid_ff)
      else $error("pixel transaction lost");

   a_stop_in_range: assert property (@(posedge clock) disable iff (reset)
      (div_ff[IDX_W].valid && div_ff[IDX_W].op == OP_PIXEL)
      |-> (div_ff[IDX_W].quo <= nm1_ff))
      else $error("selected stop beyond last stop");

   a_blend_rem: assert property (@(posedge clock) disable iff (reset)
      blend_ff[CH_W].valid
      |-> (blend_ff[CH_W].ch[0].rem < PROD_W'(dvs_ff))
          && (blend_ff[CH_W].ch[1].rem < PROD_W'(dvs_ff))
          && (blend_ff[CH_W].ch[2].rem < PROD_W'(dvs_ff)))
      else $error("blend divider remainder not reduced");

   a_column_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff.pixel_column) <= 32'(den_ff)))
      else $error("column past row end");
`endif

endmodule

>>> dv/multi_stop_gradient_pixel_tb.sv
// multi_stop_gradient_pixel_tb: self-checking testbench for the multi-stop
// gradient pixel block, with directed edge cases and random rows over many
// register settings. Depends on msgp_pkg and multi_stop_gradient_pixel.
`timescale 1ns / 1ps

module multi_stop_gradient_pixel_tb;
   import msgp_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTINGS_PER_PHASE = 4;
   localparam int ITEMS_PER_SETTING  = 42;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   multi_stop_gradient_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the block's registers and stop table. The table is updated at the
   // edge that accepts each stop write, the registers after all four writes.
   logic [ROW_W_W-1:0]    width_reg;
   logic [STOP_CNT_W-1:0] count_reg;
   logic [COLOR_W-1:0]    left_color;
   logic [COLOR_W-1:0]    right_color;
   logic [COLOR_W-1:0]    stop_palette [MAX_STOPS];

   rsp_type pending_pixels [$];   // predicted pixels, oldest first
   rsp_type pixel_want;
   int      err_count   = 0;
   int      idle_pct    = 25;     // chance in 100 that the sender idles
   int      idle_cycles = 0;

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   //------------------------------------------------------------------
   // Predictor
   //------------------------------------------------------------------

   // c1 + floor((c2 - c1) * num / den), floor toward minus infinity
   function automatic logic [CH_W-1:0] blend_channel(logic [CH_W-1:0] c1,
                                                     logic [CH_W-1:0] c2,
                                                     int unsigned num,
                                                     int unsigned den);
      longint diff, prod, d, q;
      diff = longint'(c2) - longint'(c1);
      prod = diff * longint'(num);
      d    = longint'(den);
      if (prod >= 0)
         q = prod / d;
      else
         q = -((-prod + d - 1) / d);
      return CH_W'(longint'(c1) + q);
   endfunction

   function automatic logic [COLOR_W-1:0] blend_color(logic [COLOR_W-1:0] a,
                                                      logic [COLOR_W-1:0] b,
                                                      int unsigned num,
                                                      int unsigned den);
      return {blend_channel(a[23:16], b[23:16], num, den),
              blend_channel(a[15:8],  b[15:8],  num, den),
              blend_channel(a[7:0],   b[7:0],   num, den)};
   endfunction

   // Row width as the block uses it: zero acts as one, saturates at max.
   function automatic int unsigned row_span();
      int unsigned w;
      w = 32'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic rsp_type gradient_pixel(logic [X_W-1:0] px);
      int unsigned w, n, x, den, pos, lo, hi, rem;
      logic [COLOR_W-1:0] color;
      rsp_type r;
      w = row_span();
      n = 32'(count_reg);
      if (n > MAX_STOPS) n = MAX_STOPS;
      x = 32'(px);
      if (x > w - 1) x = w - 1;
      den = w - 1;
      if (n >= 2) begin
         if (den == 0) begin
            color = stop_palette[0];
         end else begin
            pos = x * (n - 1);
            lo  = pos / den;
            rem = pos % den;
            if (lo > n - 1) lo = n - 1;
            hi = lo + 1;
            // last column: the upper stop stays on the last one
            if (hi > n - 1) hi = n - 1;
            color = blend_color(stop_palette[lo], stop_palette[hi], rem, den);
         end
      end else begin
         color = (den == 0) ? left_color : blend_color(left_color, right_color, x, den);
      end
      r.pixel_color  = color;
      r.pixel_column = X_W'(x);
      return r;
   endfunction

   function automatic void record_req(req_type item);
      if (item.operation == OP_WRITE_STOP)
         stop_palette[item.stop_index] = item.stop_color;
      else
         pending_pixels.push_back(gradient_pixel(item.pixel_x));
   endfunction

   //------------------------------------------------------------------
   // Checking
   //------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [COLOR_W-1:0] got,
                                  input logic [COLOR_W-1:0] want);
      $display("%0t ERROR %s: got %h want %h", $time, what, got, want);
      err_count++;
   endtask

   // One result per strobe; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_data.pixel_color, '0);
         end else begin
            pixel_want = pending_pixels.pop_front();
            if (rsp_data.pixel_color !== pixel_want.pixel_color)
               report_mismatch("pixel_color", rsp_data.pixel_color,
                               pixel_want.pixel_color);
            if (rsp_data.pixel_column !== pixel_want.pixel_column)
               report_mismatch("pixel_column", COLOR_W'(rsp_data.pixel_column),
                               COLOR_W'(pixel_want.pixel_column));
         end
      end
   end

   // Watchdog: too long without any transaction moving on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("multi_stop_gradient_pixel_tb: errors");
         $finish;
      end
   end

   //------------------------------------------------------------------
   // Drivers: all called and returning at a falling edge. start stays
   // high between back-to-back transactions so it is never lowered and
   // raised in the same step.
   //------------------------------------------------------------------

   task automatic send_req(input req_type item);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      record_req(item);
      @(negedge clock);
   endtask

   // Empty the pipe; stop writes give no result, so also wait out the latency.
   task automatic drain_pipe();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (RSP_DELAY + 2) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_reg_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Writes all four registers; unused high data bits are sometimes junk.
   task automatic write_config(input logic [ROW_W_W-1:0] w, input logic [STOP_CNT_W-1:0] n,
                               input logic [COLOR_W-1:0] c0, input logic [COLOR_W-1:0] c1);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom) : '0;
      drain_pipe();
      csr_reg_write(CSR_ROW_WIDTH,
                    (junk & ~CSR_DATA_W'((1 << ROW_W_W) - 1)) | CSR_DATA_W'(w));
      csr_reg_write(CSR_STOP_COUNT,  (junk << STOP_CNT_W) | CSR_DATA_W'(n));
      csr_reg_write(CSR_START_COLOR, c0);
      csr_reg_write(CSR_END_COLOR,   c1);
      csr_we      <= 1'b0;
      width_reg   = w;
      count_reg   = n;
      left_color  = c0;
      right_color = c1;
   endtask

   function automatic req_type pixel_req(input logic [X_W-1:0] x);
      req_type t;
      t.operation  = OP_PIXEL;
      t.stop_index = STOP_IDX_W'($urandom);
      t.stop_color = COLOR_W'($urandom);
      t.pixel_x    = x;
      return t;
   endfunction

   function automatic req_type stop_req(input logic [STOP_IDX_W-1:0] idx,
                                        input logic [COLOR_W-1:0] color);
      req_type t;
      t.operation  = OP_WRITE_STOP;
      t.stop_index = idx;
      t.stop_color = color;
      t.pixel_x    = X_W'($urandom);
      return t;
   endfunction

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------

   // Reset values: width one, no stops, black; column clamps to zero.
   task automatic test_reset_state();
      send_req(pixel_req('0));
      send_req(pixel_req('1));
   endtask

   // Fill every slot before any pixel can read the table; alternating
   // black/white in slots 0 to 7 gives the largest rising and falling steps.
   task automatic test_stop_table();
      for (int i = 0; i < MAX_STOPS; i++) begin
         if (i == MAX_STOPS - 1)
            send_req(stop_req(STOP_IDX_W'(i), 24'hFFFFFF));
         else if (i < 8)
            send_req(stop_req(STOP_IDX_W'(i), (i % 2) ? 24'hFFFFFF : 24'h000000));
         else
            send_req(stop_req(STOP_IDX_W'(i), COLOR_W'($urandom)));
      end
   endtask

   // Fewer than two stops: start to end blend, both slope signs.
   task automatic test_two_color_blend();
      write_config(13'd4096, 5'd0, 24'h000000, 24'hFFFFFF);
      send_req(pixel_req(12'd0));
      send_req(pixel_req(12'd1));
      send_req(pixel_req(12'd2048));
      send_req(pixel_req(12'd4095));
      write_config(13'd4096, 5'd1, 24'hFFFFFF, 24'h12F056);
      send_req(pixel_req(12'd1));         // falling channels floor downward
      send_req(pixel_req(12'd4094));
   endtask

   // Full table across the widest row, including the last column.
   task automatic test_multi_stop();
      write_config(13'd4096, 5'd16, 24'h0, 24'h0);
      send_req(pixel_req(12'd0));
      send_req(pixel_req(12'd273));
      send_req(pixel_req(12'd4094));
      send_req(pixel_req(12'd4095));
   endtask

   // Zero width, width one, oversize width and stop count, clamped column.
   task automatic test_width_edges();
      write_config(13'd0, 5'd16, 24'hA5A5A5, 24'h5A5A5A);
      send_req(pixel_req(12'd5));
      write_config(13'd1, 5'd0, 24'hC0FFEE, 24'h000000);
      send_req(pixel_req(12'd7));
      write_config(13'h1FFF, 5'h1F, 24'h000000, 24'hFFFFFF);
      send_req(pixel_req(12'd4095));
      write_config(13'd2, 5'd17, 24'h000000, 24'hFFFFFF);
      send_req(pixel_req(12'd1));
      send_req(pixel_req(12'd100));
   endtask

   function automatic logic [ROW_W_W-1:0] rand_width();
      case ($urandom_range(9))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd2;
         3:       return ROW_W_W'($urandom_range(64, 3));
         4:       return 13'd4096;
         5:       return ROW_W_W'($urandom_range(8191, 4097));
         default: return ROW_W_W'($urandom_range(4096, 1));
      endcase
   endfunction

   function automatic logic [STOP_CNT_W-1:0] rand_count();
      case ($urandom_range(7))
         0:       return 5'd0;
         1:       return 5'd1;
         2:       return 5'd2;
         3:       return 5'd16;
         4:       return STOP_CNT_W'($urandom_range(31, 17));
         default: return STOP_CNT_W'($urandom_range(16, 2));
      endcase
   endfunction

   // Stop writes and pixels; columns mostly inside the row, with both ends and overruns mixed in.
   function automatic req_type rand_item();
      int unsigned w;
      w = row_span();
      if ($urandom_range(99) < 30)
         return stop_req(STOP_IDX_W'($urandom), COLOR_W'($urandom));
      case ($urandom_range(9))
         0, 1:    return pixel_req(X_W'(w - 1));
         2:       return pixel_req('0);
         3, 4:    return pixel_req(X_W'($urandom));
         default: return pixel_req(X_W'($urandom_range(w - 1)));
      endcase
   endfunction

   // Random settings and rows at a given sender idle rate.
   task automatic test_random_rows(input int pct);
      idle_pct = pct;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
         write_config(rand_width(), rand_count(), COLOR_W'($urandom), COLOR_W'($urandom));
         for (int k = 0; k < ITEMS_PER_SETTING; k++)
            send_req(rand_item());
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_ROW_WIDTH;
      csr_wdata   = '0;
      width_reg   = 13'd1;
      count_reg   = '0;
      left_color  = '0;
      right_color = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_stop_table();
      test_two_color_blend();
      test_multi_stop();
      test_width_edges();
      test_random_rows(25);
      test_random_rows(61);
      test_random_rows(0);

      drain_pipe();
      if (err_count == 0)
         $display("multi_stop_gradient_pixel_tb: clean");
      else
         $display("multi_stop_gradient_pixel_tb: errors");
      $finish;
   end

endmodule
